>>> sv/psort_pkg.sv
`timescale 1ns / 1ps

package psort_pkg;

    // fixed field widths
    localparam int COORD_W   = 32;
    localparam int OUT_IDX_W = 6;

    // ranking lanes in the back end
    localparam int LANES  = 8;
    localparam int LANE_W = 3;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef logic signed [COORD_W-1:0] coord_t;

    // what the back end does with a queued site
    typedef enum logic [1:0] {
        CMD_STORE      = 2'd0,
        CMD_STORE_SORT = 2'd1,
        CMD_SORT       = 2'd2,
        CMD_DROP       = 2'd3
    } cmd_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        cmd_t   cmd;
    } site_beat_t;

    // true when site a must be placed after site b
    function automatic logic site_after(
        input logic                 axis,
        input coord_t               ax,
        input coord_t               ay,
        input logic [OUT_IDX_W-1:0] ai,
        input coord_t               bx,
        input coord_t               by,
        input logic [OUT_IDX_W-1:0] bi
    );
        coord_t pa;
        coord_t pb;
        coord_t sa;
        coord_t sb;
        logic   res;
        pa = axis ? ay : ax;
        pb = axis ? by : bx;
        sa = axis ? ax : ay;
        sb = axis ? bx : by;
        if (pa != pb) begin
            res = (pa > pb);
        end else if (sa != sb) begin
            res = (sa > sb);
        end else begin
            res = (ai > bi);
        end
        return res;
    endfunction

endpackage

>>> sv/psort_front.sv
`timescale 1ns / 1ps

module psort_front #(
    parameter int MAX_SITES = 64
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  psort_pkg::coord_t      s_coord_x,
    input  psort_pkg::coord_t      s_coord_y,
    input  logic                   s_last_site,
    input  logic                   s_valid,
    output logic                   s_ready,
    output psort_pkg::site_beat_t  push_data,
    output logic                   push_valid,
    input  logic                   push_ready
);

    localparam int CNT_W = $clog2(MAX_SITES + 1);

    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             full;
    logic             accept;
    psort_pkg::cmd_t  cmd;

    // classify the incoming site against the fill level of the current set
    assign full = (fill_reg == CNT_W'(MAX_SITES));

    always_comb begin
        if (s_last_site) begin
            cmd = full ? psort_pkg::CMD_SORT : psort_pkg::CMD_STORE_SORT;
        end else begin
            cmd = full ? psort_pkg::CMD_DROP : psort_pkg::CMD_STORE;
        end
    end

    // dropped sites are taken but never queued
    assign s_ready    = push_ready;
    assign accept     = s_valid && s_ready;
    assign push_valid = s_valid && (cmd != psort_pkg::CMD_DROP);

    always_comb begin
        push_data.x   = s_coord_x;
        push_data.y   = s_coord_y;
        push_data.cmd = cmd;
    end

    // set fill count, cleared by the last site
    always_comb begin
        fill_next = fill_reg;
        if (accept) begin
            if (s_last_site) begin
                fill_next = '0;
            end else if (!full) begin
                fill_next = fill_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

endmodule

>>> sv/psort_queue.sv
`timescale 1ns / 1ps

module psort_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  psort_pkg::site_beat_t in_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    output psort_pkg::site_beat_t out_data,
    output logic                  out_valid,
    input  logic                  out_ready
);

    localparam int QW = psort_pkg::QPTR_W;

    psort_pkg::site_beat_t slot_reg [psort_pkg::QUEUE_DEPTH];
    logic [QW-1:0]         wr_ptr_reg;
    logic [QW-1:0]         wr_ptr_next;
    logic [QW-1:0]         rd_ptr_reg;
    logic [QW-1:0]         rd_ptr_next;
    logic [QW:0]           count_reg;
    logic [QW:0]           count_next;
    logic                  push;
    logic                  pop;

    assign in_ready  = (count_reg != (QW+1)'(psort_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointer and occupancy update
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (QW+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (QW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

>>> sv/psort_back.sv
`timescale 1ns / 1ps

module psort_back #(
    parameter int MAX_SITES = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                sort_axis,
    input  psort_pkg::site_beat_t               q_data,
    input  logic                                q_valid,
    output logic                                q_ready,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [psort_pkg::OUT_IDX_W-1:0]     m_site_index,
    output psort_pkg::coord_t                   m_out_x,
    output psort_pkg::coord_t                   m_out_y,
    output logic                                m_end_of_set
);

    localparam int IDX_W = (MAX_SITES > 2) ? $clog2(MAX_SITES) : 1;
    localparam int CNT_W = $clog2(MAX_SITES + 1);
    localparam int PTR_W = CNT_W + psort_pkg::LANE_W;
    localparam int LN    = psort_pkg::LANES;
    localparam int LW    = psort_pkg::LANE_W;
    localparam int OW    = psort_pkg::OUT_IDX_W;

    typedef enum logic [6:0] {
        S_LOAD     = 7'b0000001,
        S_PIVOT    = 7'b0000010,
        S_SCAN     = 7'b0000100,
        S_RANK     = 7'b0001000,
        S_EMIT_IDX = 7'b0010000,
        S_EMIT_XY  = 7'b0100000,
        S_EMIT_OUT = 7'b1000000
    } state_t;

    // site and order stores
    psort_pkg::coord_t x_mem     [MAX_SITES];
    psort_pkg::coord_t y_mem     [MAX_SITES];
    logic [IDX_W-1:0]  order_mem [MAX_SITES];

    // ranking lanes
    psort_pkg::coord_t lane_x_reg   [LN];
    psort_pkg::coord_t lane_y_reg   [LN];
    logic [IDX_W-1:0]  lane_idx_reg [LN];
    logic              lane_ok_reg  [LN];
    logic [IDX_W-1:0]  rank_reg     [LN];
    logic              lane_hit     [LN];

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  n_reg;
    logic [CNT_W-1:0]  n_next;
    logic [PTR_W-1:0]  base_reg;
    logic [PTR_W-1:0]  base_next;
    logic [PTR_W-1:0]  cnt_reg;
    logic [PTR_W-1:0]  cnt_next;
    logic [CNT_W-1:0]  e_ptr_reg;
    logic [CNT_W-1:0]  e_ptr_next;
    logic              rd_vld_reg;
    logic              rd_vld_next;
    logic [PTR_W-1:0]  rd_tag_reg;
    logic [PTR_W-1:0]  rd_tag_next;

    logic [IDX_W-1:0]  rd_addr;
    psort_pkg::coord_t x_rd_reg;
    psort_pkg::coord_t y_rd_reg;
    logic [IDX_W-1:0]  ord_rd_reg;

    logic              m_valid_reg;
    logic [OW-1:0]     m_site_index_reg;
    psort_pkg::coord_t m_out_x_reg;
    psort_pkg::coord_t m_out_y_reg;
    logic              m_end_of_set_reg;

    logic              q_take;
    logic              do_store;
    logic              do_sort;
    logic [PTR_W-1:0]  n_ext;
    logic [PTR_W-1:0]  pivot_ptr;
    logic [PTR_W-1:0]  base_plus;
    logic [LW-1:0]     rank_lane;
    logic              e_last;
    logic              emit_load;

    assign q_ready   = (state_reg == S_LOAD);
    assign q_take    = q_valid && q_ready;
    assign do_store  = q_data.cmd inside {psort_pkg::CMD_STORE, psort_pkg::CMD_STORE_SORT};
    assign do_sort   = q_data.cmd inside {psort_pkg::CMD_STORE_SORT, psort_pkg::CMD_SORT};
    assign n_ext     = PTR_W'(n_reg);
    assign pivot_ptr = base_reg + rd_tag_reg;
    assign base_plus = base_reg + PTR_W'(LN);
    assign rank_lane = cnt_reg[LW-1:0];
    assign e_last    = ((e_ptr_reg + CNT_W'(1)) == n_reg);
    assign emit_load = (state_reg == S_EMIT_OUT) && (!m_valid_reg || m_ready);

    // coordinate read address
    always_comb begin
        case (state_reg)
            S_PIVOT:   rd_addr = IDX_W'(base_reg + cnt_reg);
            S_SCAN:    rd_addr = IDX_W'(cnt_reg);
            S_EMIT_XY,
            S_EMIT_OUT: rd_addr = ord_rd_reg;
            default:   rd_addr = '0;
        endcase
    end

    // sequencer: load, rank in groups of lanes, then emit
    always_comb begin
        state_next  = state_reg;
        n_next      = n_reg;
        base_next   = base_reg;
        cnt_next    = cnt_reg;
        e_ptr_next  = e_ptr_reg;
        rd_vld_next = 1'b0;
        rd_tag_next = rd_tag_reg;
        case (state_reg)
            S_LOAD: begin
                if (q_take) begin
                    if (do_store) begin
                        n_next = n_reg + CNT_W'(1);
                    end
                    if (do_sort) begin
                        state_next = S_PIVOT;
                        base_next  = '0;
                        cnt_next   = '0;
                    end
                end
            end
            S_PIVOT: begin
                if (cnt_reg < PTR_W'(LN)) begin
                    rd_vld_next = 1'b1;
                    rd_tag_next = cnt_reg;
                    cnt_next    = cnt_reg + PTR_W'(1);
                end else begin
                    state_next = S_SCAN;
                    cnt_next   = '0;
                end
            end
            S_SCAN: begin
                if (cnt_reg < n_ext) begin
                    rd_vld_next = 1'b1;
                    rd_tag_next = cnt_reg;
                    cnt_next    = cnt_reg + PTR_W'(1);
                end else begin
                    state_next = S_RANK;
                    cnt_next   = '0;
                end
            end
            S_RANK: begin
                if (cnt_reg == PTR_W'(LN - 1)) begin
                    base_next = base_plus;
                    cnt_next  = '0;
                    if (base_plus >= n_ext) begin
                        state_next = S_EMIT_IDX;
                        e_ptr_next = '0;
                    end else begin
                        state_next = S_PIVOT;
                    end
                end else begin
                    cnt_next = cnt_reg + PTR_W'(1);
                end
            end
            S_EMIT_IDX: begin
                state_next = S_EMIT_XY;
            end
            S_EMIT_XY: begin
                state_next = S_EMIT_OUT;
            end
            S_EMIT_OUT: begin
                if (emit_load) begin
                    if (e_last) begin
                        state_next = S_LOAD;
                        n_next     = '0;
                    end else begin
                        state_next = S_EMIT_IDX;
                        e_ptr_next = e_ptr_reg + CNT_W'(1);
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_LOAD;
            n_reg      <= '0;
            base_reg   <= '0;
            cnt_reg    <= '0;
            e_ptr_reg  <= '0;
            rd_vld_reg <= 1'b0;
            rd_tag_reg <= '0;
        end else begin
            state_reg  <= state_next;
            n_reg      <= n_next;
            base_reg   <= base_next;
            cnt_reg    <= cnt_next;
            e_ptr_reg  <= e_ptr_next;
            rd_vld_reg <= rd_vld_next;
            rd_tag_reg <= rd_tag_next;
        end
    end

    // coordinate stores: one write, one registered read
    always_ff @(posedge aclk) begin
        if (q_take && do_store) begin
            x_mem[n_reg[IDX_W-1:0]] <= q_data.x;
            y_mem[n_reg[IDX_W-1:0]] <= q_data.y;
        end
        x_rd_reg <= x_mem[rd_addr];
        y_rd_reg <= y_mem[rd_addr];
    end

    // order store: ranks written per lane, read back for emission
    always_ff @(posedge aclk) begin
        if ((state_reg == S_RANK) && lane_ok_reg[rank_lane]) begin
            order_mem[rank_reg[rank_lane]] <= lane_idx_reg[rank_lane];
        end
        if (state_reg == S_EMIT_IDX) begin
            ord_rd_reg <= order_mem[e_ptr_reg[IDX_W-1:0]];
        end
    end

    // lane comparators against the streamed site
    always_comb begin
        for (int k = 0; k < LN; k++) begin
            lane_hit[k] = psort_pkg::site_after(sort_axis,
                              lane_x_reg[k], lane_y_reg[k], OW'(lane_idx_reg[k]),
                              x_rd_reg, y_rd_reg, OW'(rd_tag_reg));
        end
    end

    // pivot capture and rank counting
    always_ff @(posedge aclk) begin
        if ((state_reg == S_PIVOT) && rd_vld_reg) begin
            lane_x_reg[rd_tag_reg[LW-1:0]]   <= x_rd_reg;
            lane_y_reg[rd_tag_reg[LW-1:0]]   <= y_rd_reg;
            lane_idx_reg[rd_tag_reg[LW-1:0]] <= IDX_W'(pivot_ptr);
            lane_ok_reg[rd_tag_reg[LW-1:0]]  <= (pivot_ptr < n_ext);
            rank_reg[rd_tag_reg[LW-1:0]]     <= '0;
        end
        if ((state_reg == S_SCAN) && rd_vld_reg) begin
            for (int k = 0; k < LN; k++) begin
                if (lane_hit[k]) begin
                    rank_reg[k] <= rank_reg[k] + IDX_W'(1);
                end
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (emit_load) begin
            m_site_index_reg <= OW'(ord_rd_reg);
            m_out_x_reg      <= x_rd_reg;
            m_out_y_reg      <= y_rd_reg;
            m_end_of_set_reg <= e_last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_site_index = m_site_index_reg;
    assign m_out_x      = m_out_x_reg;
    assign m_out_y      = m_out_y_reg;
    assign m_end_of_set = m_end_of_set_reg;

    // checks
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= CNT_W'(MAX_SITES))
        else $error("site count beyond capacity");

    a_pivot_base: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PIVOT) |-> (base_reg < n_ext))
        else $error("pivot group starts past the stored set");

    a_rank_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_RANK) && lane_ok_reg[rank_lane])
        |-> (CNT_W'(rank_reg[rank_lane]) < n_reg))
        else $error("rank outside the stored set");

    a_emit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_load |-> (e_ptr_reg < n_reg))
        else $error("emission pointer past the stored set");

    a_end_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_load && e_last) |=> ((state_reg == S_LOAD) && (n_reg == '0)))
        else $error("set not closed after its final beat");

endmodule

>>> sv/point_lexicographic_sorter_top.sv
`timescale 1ns / 1ps

// Two-key site sorter. Sites enter on the s_ channel (x, y, last flag), one
// beat each, and are stored under their load position. A beat with
// s_last_site set closes the set: the block ranks all stored sites and sends
// them out on the m_ channel in ascending order, x then y or y then x as the
// sort_axis register (cfg_ channel, bit 0) selects. Equal sites leave in
// load order; m_end_of_set marks the final beat of a set. Sites beyond
// MAX_SITES in one set are taken and discarded.
// Throughput: sites load at one per cycle through a four-entry queue while
// the queue has room. The back end ranks eight sites per pass over the
// coordinate store's single read port, then emits each site through an
// order read, a coordinate read and an output load. While ranking or
// emitting, the queue fills and s_ready drops. A stalled m_ready holds the
// output register and pauses emission only.
// Reset (aresetn low, synchronous) empties the queue, drops any partial set
// and sets sort_axis to 0. Write cfg only while the block is idle.
module point_lexicographic_sorter_top #(
    parameter int MAX_SITES = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_data,
    input  psort_pkg::coord_t                   s_coord_x,
    input  psort_pkg::coord_t                   s_coord_y,
    input  logic                                s_last_site,
    input  logic                                s_valid,
    output logic                                s_ready,
    output logic [psort_pkg::OUT_IDX_W-1:0]     m_site_index,
    output psort_pkg::coord_t                   m_out_x,
    output psort_pkg::coord_t                   m_out_y,
    output logic                                m_end_of_set,
    output logic                                m_valid,
    input  logic                                m_ready
);

    logic                  sort_axis_reg;
    psort_pkg::site_beat_t push_data;
    logic                  push_valid;
    logic                  push_ready;
    psort_pkg::site_beat_t q_data;
    logic                  q_valid;
    logic                  q_ready;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sort_axis_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            sort_axis_reg <= cfg_data;
        end
    end

    psort_front #(
        .MAX_SITES (MAX_SITES)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_coord_x   (s_coord_x),
        .s_coord_y   (s_coord_y),
        .s_last_site (s_last_site),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .push_data   (push_data),
        .push_valid  (push_valid),
        .push_ready  (push_ready)
    );

    psort_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_data   (push_data),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .out_data  (q_data),
        .out_valid (q_valid),
        .out_ready (q_ready)
    );

    psort_back #(
        .MAX_SITES (MAX_SITES)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .sort_axis    (sort_axis_reg),
        .q_data       (q_data),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_site_index (m_site_index),
        .m_out_x      (m_out_x),
        .m_out_y      (m_out_y),
        .m_end_of_set (m_end_of_set)
    );

endmodule

>>> bench/point_lexicographic_sorter_top_test.sv
`timescale 1ns / 1ps

module point_lexicographic_sorter_top_test;

    localparam int                SITE_CAP    = 64;
    localparam int                RANDOM_GOAL = 370;
    localparam int                IDLE_GUARD  = 24;
    localparam psort_pkg::coord_t C_MIN       = 32'sh8000_0000;
    localparam psort_pkg::coord_t C_MAX       = 32'sh7FFF_FFFF;
    localparam psort_pkg::coord_t C_ZERO      = 32'sh0000_0000;
    localparam psort_pkg::coord_t C_NEG1      = 32'shFFFF_FFFF;
    localparam psort_pkg::coord_t C_ONE       = 32'sh0001_0000;

    // one sorted site as it should leave the block
    typedef struct {
        logic [psort_pkg::OUT_IDX_W-1:0] idx;
        psort_pkg::coord_t               x;
        psort_pkg::coord_t               y;
        logic                            eos;
    } ranked_site_t;

    // tracks the loaded set and the sorted beats still owed by the block
    class site_rank_board;
        logic              axis;
        psort_pkg::coord_t xs[SITE_CAP];
        psort_pkg::coord_t ys[SITE_CAP];
        int unsigned       loaded;
        ranked_site_t      sites_due[$];
        int unsigned       faults;

        function new();
            axis   = 1'b0;
            loaded = 0;
            faults = 0;
        endfunction

        function void set_axis(logic v);
            axis = v;
        endfunction

        function int unsigned due();
            return sites_due.size();
        endfunction

        // true when stored site a ranks behind stored site b
        function bit ranks_behind(int a, int b);
            psort_pkg::coord_t pa;
            psort_pkg::coord_t pb;
            psort_pkg::coord_t sa;
            psort_pkg::coord_t sb;
            pa = axis ? ys[a] : xs[a];
            pb = axis ? ys[b] : xs[b];
            sa = axis ? xs[a] : ys[a];
            sb = axis ? xs[b] : ys[b];
            if (pa != pb) return pa > pb;
            if (sa != sb) return sa > sb;
            return a > b;
        endfunction

        // store an accepted site and, on the closing one, rank the whole set
        function void note_site(psort_pkg::coord_t x, psort_pkg::coord_t y, logic last);
            int           order[SITE_CAP];
            int           j;
            ranked_site_t r;
            if (loaded < SITE_CAP) begin
                xs[loaded] = x;
                ys[loaded] = y;
                loaded++;
            end
            if (!last) return;
            for (int i = 0; i < loaded; i++) begin
                j = i;
                while (j > 0 && ranks_behind(order[j-1], i)) begin
                    order[j] = order[j-1];
                    j--;
                end
                order[j] = i;
            end
            for (int i = 0; i < loaded; i++) begin
                r.idx = order[i][psort_pkg::OUT_IDX_W-1:0];
                r.x   = xs[order[i]];
                r.y   = ys[order[i]];
                r.eos = (i == loaded - 1);
                sites_due.push_back(r);
            end
            loaded = 0;
        endfunction

        // compare one output beat with the oldest owed site
        function void check_site(logic [psort_pkg::OUT_IDX_W-1:0] idx,
                                 psort_pkg::coord_t x, psort_pkg::coord_t y,
                                 logic eos);
            ranked_site_t e;
            if (sites_due.size() == 0) begin
                $display("%0t unexpected beat: index %0d x %h y %h end %b",
                         $time, idx, x, y, eos);
                faults++;
                return;
            end
            e = sites_due.pop_front();
            if (idx !== e.idx) begin
                $display("%0t site_index expected %0d actual %0d", $time, e.idx, idx);
                faults++;
            end
            if (x !== e.x) begin
                $display("%0t out_x expected %h actual %h", $time, e.x, x);
                faults++;
            end
            if (y !== e.y) begin
                $display("%0t out_y expected %h actual %h", $time, e.y, y);
                faults++;
            end
            if (eos !== e.eos) begin
                $display("%0t end_of_set expected %b actual %b", $time, e.eos, eos);
                faults++;
            end
        endfunction
    endclass

    logic                            aclk;
    logic                            aresetn;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic                            cfg_data;
    psort_pkg::coord_t               s_coord_x;
    psort_pkg::coord_t               s_coord_y;
    logic                            s_last_site;
    logic                            s_valid;
    logic                            s_ready;
    logic [psort_pkg::OUT_IDX_W-1:0] m_site_index;
    psort_pkg::coord_t               m_out_x;
    psort_pkg::coord_t               m_out_y;
    logic                            m_end_of_set;
    logic                            m_valid;
    logic                            m_ready = 1'b0;

    site_rank_board board;
    int             burst_left = 1;
    int             ready_mode = 0;
    int unsigned    ready_tick = 0;

    point_lexicographic_sorter_top #(
        .MAX_SITES(SITE_CAP)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_coord_x   (s_coord_x),
        .s_coord_y   (s_coord_y),
        .s_last_site (s_last_site),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .m_site_index(m_site_index),
        .m_out_x     (m_out_x),
        .m_out_y     (m_out_y),
        .m_end_of_set(m_end_of_set),
        .m_valid     (m_valid),
        .m_ready     (m_ready)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // run limit
    initial begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // receiver stalls, under one of four patterns picked at random
    always @(posedge aclk) begin
        ready_tick++;
        if (ready_tick % 50 == 0) begin
            ready_mode = $urandom_range(0, 3);
        end
        case (ready_mode)
            0: begin
                m_ready <= 1'b1;
            end
            1: begin
                m_ready <= 1'($urandom_range(0, 1));
            end
            2: begin
                m_ready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                m_ready <= (ready_tick % 4 == 0);
            end
        endcase
    end

    // output beats are sampled mid-cycle and taken at the next edge
    always @(negedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_site(m_site_index, m_out_x, m_out_y, m_end_of_set);
        end
    end

    // random coordinate, biased towards extremes and clashing values
    function automatic psort_pkg::coord_t pick_coord();
        int                sel;
        psort_pkg::coord_t v;
        sel = $urandom_range(0, 9);
        case (sel)
            0: v = C_MIN;
            1: v = C_MAX;
            2: v = C_ZERO;
            3: v = C_NEG1;
            4, 5: v = psort_pkg::coord_t'(int'($urandom_range(0, 6)) - 3) <<< 16;
            default: v = psort_pkg::coord_t'($urandom);
        endcase
        return v;
    endfunction

    // one site beat, then a gap if the burst is spent
    task automatic send_site(psort_pkg::coord_t x, psort_pkg::coord_t y, logic last);
        logic took;
        s_valid     <= 1'b1;
        s_coord_x   <= x;
        s_coord_y   <= y;
        s_last_site <= last;
        do begin
            @(negedge aclk);
            took = s_ready;
            @(posedge aclk);
        end while (!took);
        board.note_site(x, y, last);
        burst_left--;
        if (burst_left <= 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(1, 40);
        end
    endtask

    // drop valid and let the block finish every owed beat
    task automatic await_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.due() != 0) @(posedge aclk);
        repeat (IDLE_GUARD) @(posedge aclk);
    endtask

    // sort axis write, only while idle
    task automatic write_axis(logic v);
        logic took;
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do begin
            @(negedge aclk);
            took = cfg_ready;
            @(posedge aclk);
        end while (!took);
        cfg_valid <= 1'b0;
        board.set_axis(v);
    endtask

    // a set of random sites, the last one closing it
    task automatic send_set(int size);
        for (int k = 0; k < size; k++) begin
            send_site(pick_coord(), pick_coord(), k == size - 1);
        end
    endtask

    initial begin
        int sent;
        int set_no;
        int size;
        int pick;
        board       = new();
        aresetn     <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_data    <= 1'b0;
        s_valid     <= 1'b0;
        s_coord_x   <= C_ZERO;
        s_coord_y   <= C_ZERO;
        s_last_site <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // extremes, sign boundaries and clashing sites under the reset axis
        send_site(C_MAX,  C_MIN,  1'b0);
        send_site(C_MIN,  C_MAX,  1'b0);
        send_site(C_ZERO, C_ZERO, 1'b0);
        send_site(C_NEG1, C_NEG1, 1'b0);
        send_site(C_ZERO, C_NEG1, 1'b0);
        send_site(C_NEG1, C_ZERO, 1'b0);
        send_site(C_ZERO, C_ZERO, 1'b0);
        send_site(C_MIN,  C_MIN,  1'b0);
        send_site(C_MAX,  C_MAX,  1'b1);
        // lone site closing its own set
        send_site(32'sh1234_5678, 32'sh9ABC_DEF0, 1'b1);
        await_idle();

        // same kind of set ranked y first
        write_axis(1'b1);
        send_site(C_MIN,  C_ONE,  1'b0);
        send_site(C_MAX,  C_ZERO, 1'b0);
        send_site(C_ZERO, C_ZERO, 1'b0);
        send_site(C_MIN,  C_ZERO, 1'b0);
        send_site(C_ONE,  C_MIN,  1'b0);
        send_site(C_ONE,  C_MAX,  1'b0);
        send_site(C_ZERO, C_ZERO, 1'b0);
        send_site(C_NEG1, C_NEG1, 1'b0);
        send_site(C_MAX,  C_MAX,  1'b1);
        await_idle();
        write_axis(1'b0);

        // random sets: mostly small, a few full and overflowing ones
        sent   = 0;
        set_no = 0;
        while (sent < RANDOM_GOAL) begin
            pick = $urandom_range(0, 99);
            if (set_no == 0 || (set_no > 1 && pick < 3)) begin
                size = SITE_CAP + $urandom_range(1, 4);
            end else if (set_no == 1 || pick < 6) begin
                size = SITE_CAP;
            end else begin
                size = $urandom_range(1, 12);
            end
            send_set(size);
            sent += (size > SITE_CAP) ? SITE_CAP : size;
            set_no++;
            if ($urandom_range(0, 4) == 0) begin
                await_idle();
                write_axis(1'($urandom_range(0, 1)));
            end
        end

        await_idle();
        if (board.faults == 0 && board.due() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/psort_pkg.sv
sv/psort_front.sv
sv/psort_queue.sv
sv/psort_back.sv
sv/point_lexicographic_sorter_top.sv
bench/point_lexicographic_sorter_top_test.sv
